### hw/rtl/dhfk_pkg.sv
`default_nettype none
package dhfk_pkg;

  // default sizes
  localparam int MAX_JOINTS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 16;

  // serial multiplier digit size
  localparam int DIGIT_W  = 8;
  localparam int N_DIGITS = 32 / DIGIT_W;
  localparam int DCNT_W   = $clog2(N_DIGITS);

  // CORDIC constants, 30 fractional bits
  localparam int     CORDIC_STEPS = 30;
  localparam int     CSTEP_W      = 5;
  localparam longint PI_Q30       = 64'd3373259426;
  localparam longint TWO_PI_Q30   = 64'd6746518852;
  localparam longint HALF_PI_Q30  = 64'd1686629713;
  localparam longint GAIN_Q30     = 64'd652032874;

  // floor(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
  };

  // input word opcodes
  typedef enum logic [1:0] {
    OP_LINK  = 2'd0,
    OP_BASE  = 2'd1,
    OP_TOOL  = 2'd2,
    OP_JOINT = 2'd3
  } op_t;

  // one link table entry
  typedef struct packed {
    logic               kind;
    logic signed [31:0] offset;
    logic signed [31:0] length;
    logic signed [31:0] tw_cos;
    logic signed [31:0] tw_sin;
    logic signed [31:0] an_cos;
    logic signed [31:0] an_sin;
  } link_t;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sh80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/dhfk_mul.sv
`default_nettype none
// Signed 32x32 product, one 8-bit digit of b per cycle, rounded to FRAC_BITS.
module dhfk_mul #(
  parameter int FRAC_BITS = dhfk_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic signed [63:0]      prod
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam int DW = dhfk_pkg::DIGIT_W;

  logic                            busy_r;
  logic                            rnd_r;
  logic                            done_r;
  logic [dhfk_pkg::DCNT_W-1:0]     cnt_r;
  logic signed [31:0]              a_r;
  logic [31:0]                     b_r;
  logic signed [63:0]              acc_r;
  logic signed [63:0]              prod_r;

  logic signed [DW:0]   digit;
  logic signed [DW+32:0] pp;
  logic signed [63:0]   pp64;
  logic signed [63:0]   term;
  logic                 top_digit;

  // low digits are unsigned, the top one carries the sign
  assign top_digit = (cnt_r == dhfk_pkg::DCNT_W'(dhfk_pkg::N_DIGITS - 1));
  assign digit     = $signed({top_digit & b_r[DW-1], b_r[DW-1:0]});
  assign pp        = a_r * digit;
  assign pp64      = 64'(pp);
  assign term      = pp64 <<< (32'(cnt_r) * DW);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (top_digit) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + term;
      b_r   <= b_r >> DW;
    end else if (rnd_r) begin
      prod_r <= (acc_r + HALF) >>> FRAC_BITS;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule
`default_nettype wire

### hw/rtl/dhfk_cordic.sv
`default_nettype none
// Angle reduction by serial restoring remainder, then 30 CORDIC rotations.
module dhfk_cordic #(
  parameter int FRAC_BITS = dhfk_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output logic                    done,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);

  localparam int SH = 30 - FRAC_BITS;
  localparam int MW = 63 - FRAC_BITS;
  localparam int ZW = 35;
  localparam int XW = 34;
  localparam int CW = dhfk_pkg::CSTEP_W;

  localparam logic [MW-1:0]        D_INIT = MW'(dhfk_pkg::TWO_PI_Q30) << (SH - 1);
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(dhfk_pkg::PI_Q30);
  localparam logic signed [ZW-1:0] TPI_Z  = ZW'(dhfk_pkg::TWO_PI_Q30);
  localparam logic signed [ZW-1:0] HPI_Z  = ZW'(dhfk_pkg::HALF_PI_Q30);
  localparam logic signed [XW-1:0] GAIN_X = XW'(dhfk_pkg::GAIN_Q30);
  localparam logic signed [XW-1:0] RND_X  = XW'(64'sd1 <<< (29 - FRAC_BITS));

  typedef enum logic [6:0] {
    CS_IDLE = 7'b0000001,
    CS_RED  = 7'b0000010,
    CS_SIGN = 7'b0000100,
    CS_WRAP = 7'b0001000,
    CS_FOLD = 7'b0010000,
    CS_ROT  = 7'b0100000,
    CS_FIN  = 7'b1000000
  } cstate_t;

  cstate_t                 state_r;
  logic [CW-1:0]           cnt_r;
  logic                    done_r;
  logic                    neg_in_r;
  logic                    neg_out_r;
  logic [MW-1:0]           mag_r;
  logic [MW-1:0]           d_r;
  logic signed [ZW-1:0]    z_r;
  logic signed [XW-1:0]    x_r;
  logic signed [XW-1:0]    y_r;
  logic signed [31:0]      cos_r;
  logic signed [31:0]      sin_r;

  logic signed [63:0]   z0;
  logic signed [63:0]   z0_abs;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] atan_z;
  logic signed [XW-1:0] xf;
  logic signed [XW-1:0] yf;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;

  assign z0     = $signed({{32{angle[31]}}, angle}) <<< SH;
  assign z0_abs = angle[31] ? -z0 : z0;
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_z = $signed({3'b000, dhfk_pkg::ATAN_TAB[cnt_r]});
  assign xf     = neg_out_r ? -x_r : x_r;
  assign yf     = neg_out_r ? -y_r : y_r;
  assign xr     = (xf + RND_X) >>> SH;
  assign yr     = (yf + RND_X) >>> SH;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        CS_IDLE: begin
          cnt_r <= '0;
          if (start) state_r <= CS_RED;
        end
        CS_RED: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(SH - 1)) state_r <= CS_SIGN;
        end
        CS_SIGN: state_r <= CS_WRAP;
        CS_WRAP: state_r <= CS_FOLD;
        CS_FOLD: begin
          cnt_r   <= '0;
          state_r <= CS_ROT;
        end
        CS_ROT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(dhfk_pkg::CORDIC_STEPS - 1)) state_r <= CS_FIN;
        end
        CS_FIN: begin
          done_r  <= 1'b1;
          state_r <= CS_IDLE;
        end
        default: state_r <= CS_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      CS_IDLE: begin
        if (start) begin
          neg_in_r <= angle[31];
          mag_r    <= MW'(z0_abs);
          d_r      <= D_INIT;
        end
      end
      CS_RED: begin
        // one quotient bit per cycle
        if (mag_r >= d_r) mag_r <= mag_r - d_r;
        d_r <= d_r >> 1;
      end
      CS_SIGN: begin
        // remainder keeps the dividend's sign
        z_r <= neg_in_r ? -$signed({1'b0, mag_r[ZW-2:0]}) : $signed({1'b0, mag_r[ZW-2:0]});
      end
      CS_WRAP: begin
        if (z_r > PI_Z) begin
          z_r <= z_r - TPI_Z;
        end else if (z_r < -PI_Z) begin
          z_r <= z_r + TPI_Z;
        end
      end
      CS_FOLD: begin
        // fold into [-pi/2, pi/2], negate results later
        x_r <= GAIN_X;
        y_r <= '0;
        if (z_r > HPI_Z) begin
          z_r       <= z_r - PI_Z;
          neg_out_r <= 1'b1;
        end else if (z_r < -HPI_Z) begin
          z_r       <= z_r + PI_Z;
          neg_out_r <= 1'b1;
        end else begin
          neg_out_r <= 1'b0;
        end
      end
      CS_ROT: begin
        if (z_r >= 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_z;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_z;
        end
      end
      CS_FIN: begin
        cos_r <= xr[31:0];
        sin_r <= yr[31:0];
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

### hw/rtl/dh_forward_kinematics_chain_top.sv
// Serial-chain Denavit-Hartenberg forward kinematics, signed fixed point.
// Input words (valid/stall): op 0 loads a link table entry, ops 1 and 2 load
// a row of the base or tool frame, op 3 applies a joint value. Loads give
// no output; out-of-range indexes are dropped.
// A joint word yields three output words, the rows of the new chain frame;
// with final_joint set it yields three more rows, chain times tool frame.
// end_of_run marks the last row of a joint word.
// A joint word runs 6 link products and a matrix product of 36 products on
// the shared multiplier, after the CORDIC for a revolute joint (a prismatic
// one skips it); the tool rows take one more matrix product.
// One joint word is worked at a time; in_stall is high until its last row
// is taken. While out_stall is high the current row holds and work pauses.
// Reset (synchronous, rst_n low) sets base, tool and chain frames to
// identity; link entries must be loaded before use.
`default_nettype none
module dh_forward_kinematics_chain_top #(
  parameter int MAX_JOINTS = dhfk_pkg::MAX_JOINTS_DEF,
  parameter int FRAC_BITS  = dhfk_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [2:0]         in_index,
  input  wire logic               in_joint_kind,
  input  wire logic signed [31:0] in_word0,
  input  wire logic signed [31:0] in_word1,
  input  wire logic signed [31:0] in_word2,
  input  wire logic signed [31:0] in_word3,
  input  wire logic signed [31:0] in_word4,
  input  wire logic signed [31:0] in_word5,
  input  wire logic               in_final_joint,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_frame_index,
  output logic [1:0]              out_row,
  output logic signed [31:0]      out_elem0,
  output logic signed [31:0]      out_elem1,
  output logic signed [31:0]      out_elem2,
  output logic signed [31:0]      out_elem3,
  output logic                    out_is_tool,
  output logic                    out_end_of_run
);

  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SEL  = 6'b000010,
    ST_TRIG = 6'b000100,
    ST_LINK = 6'b001000,
    ST_MAT  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  dhfk_pkg::link_t tbl [MAX_JOINTS];
  dhfk_pkg::link_t link_r;

  logic signed [31:0] base_r  [3][4];
  logic signed [31:0] tool_r  [3][4];
  logic signed [31:0] chain_r [3][4];
  logic signed [31:0] res_r   [3][4];
  logic signed [31:0] lmp_r   [6];

  logic [2:0]         idx_r;
  logic               final_r;
  logic signed [31:0] w0_r;
  logic signed [31:0] ct_r;
  logic signed [31:0] st_r;
  logic signed [31:0] dd_r;
  logic signed [63:0] acc_r;
  logic               pend_r;
  logic [2:0]         lk_r;
  logic [1:0]         r_r;
  logic [1:0]         c_r;
  logic [1:0]         k_r;
  logic [1:0]         er_r;
  logic               tool_pass_r;

  logic [3:0]         idx_ext;
  logic [AW-1:0]      tbl_addr;
  logic               idx_ok;
  logic               row_ok;
  logic               in_acc;
  logic               out_acc;
  logic               joint_go;
  logic               last_row;
  logic [1:0]         lcol;
  logic signed [31:0] lhs;
  logic signed [31:0] rhs;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_start;
  logic               mul_done;
  logic signed [63:0] mul_prod;
  logic               mul_fin;
  logic               cor_start;
  logic               cor_done;
  logic signed [31:0] cor_cos;
  logic signed [31:0] cor_sin;

  // input decode
  assign idx_ext  = {1'b0, in_index};
  assign tbl_addr = idx_ext[AW-1:0];
  assign idx_ok   = (32'(idx_ext) < MAX_JOINTS);
  assign row_ok   = (in_index < 3'd3);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign joint_go = in_acc && (in_op == dhfk_pkg::OP_JOINT) && idx_ok;

  assign out_valid = (state_r == ST_EMIT);
  assign out_acc   = out_valid && !out_stall;
  assign last_row  = (er_r == 2'd2);
  assign mul_fin   = pend_r && mul_done;

  // shared arithmetic units
  assign mul_start = ((state_r == ST_LINK) || (state_r == ST_MAT)) && !pend_r;
  assign cor_start = (state_r == ST_SEL) && !link_r.kind;

  dhfk_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  dhfk_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (w0_r),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  // left operand: column k while issuing, translation column when folding it in
  assign lcol = pend_r ? 2'd3 : k_r;
  assign lhs  = chain_r[r_r][lcol];

  // right operand: tool frame or the link matrix
  always_comb begin
    rhs = '0;
    if (tool_pass_r) begin
      rhs = tool_r[k_r][c_r];
    end else begin
      case ({k_r, c_r})
        4'b0000: rhs = ct_r;
        4'b0001: rhs = lmp_r[0];
        4'b0010: rhs = lmp_r[1];
        4'b0011: rhs = lmp_r[2];
        4'b0100: rhs = st_r;
        4'b0101: rhs = lmp_r[3];
        4'b0110: rhs = lmp_r[4];
        4'b0111: rhs = lmp_r[5];
        4'b1001: rhs = link_r.tw_sin;
        4'b1010: rhs = link_r.tw_cos;
        4'b1011: rhs = dd_r;
        default: rhs = '0;
      endcase
    end
  end

  // multiplier operands
  always_comb begin
    mul_a = lhs;
    mul_b = rhs;
    if (state_r == ST_LINK) begin
      case (lk_r)
        3'd0:    begin mul_a = st_r;          mul_b = link_r.tw_cos; end
        3'd1:    begin mul_a = st_r;          mul_b = link_r.tw_sin; end
        3'd2:    begin mul_a = link_r.length; mul_b = ct_r;          end
        3'd3:    begin mul_a = ct_r;          mul_b = link_r.tw_cos; end
        3'd4:    begin mul_a = ct_r;          mul_b = link_r.tw_sin; end
        default: begin mul_a = link_r.length; mul_b = st_r;          end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (joint_go) state_nxt = ST_SEL;
      ST_SEL:  state_nxt = link_r.kind ? ST_LINK : ST_TRIG;
      ST_TRIG: if (cor_done) state_nxt = ST_LINK;
      ST_LINK: if (mul_fin && (lk_r == 3'd5)) state_nxt = ST_MAT;
      ST_MAT: begin
        if (mul_fin && (k_r == 2'd2) && (c_r == 2'd3) && (r_r == 2'd2)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && last_row) begin
          state_nxt = (tool_pass_r || !final_r) ? ST_IDLE : ST_MAT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      lk_r        <= '0;
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
      er_r        <= '0;
      tool_pass_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r) inside
        ST_IDLE: begin
          pend_r      <= 1'b0;
          lk_r        <= '0;
          r_r         <= '0;
          c_r         <= '0;
          k_r         <= '0;
          er_r        <= '0;
          tool_pass_r <= 1'b0;
        end
        ST_SEL, ST_TRIG: ;
        ST_LINK: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (mul_done) begin
            pend_r <= 1'b0;
            lk_r   <= lk_r + 1'b1;
          end
        end
        ST_MAT: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (mul_done) begin
            pend_r <= 1'b0;
            if (k_r == 2'd2) begin
              k_r <= '0;
              if (c_r == 2'd3) begin
                c_r <= '0;
                r_r <= (r_r == 2'd2) ? 2'd0 : r_r + 1'b1;
              end else begin
                c_r <= c_r + 1'b1;
              end
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (last_row) begin
              er_r <= '0;
              if (!tool_pass_r && final_r) tool_pass_r <= 1'b1;
            end else begin
              er_r <= er_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // link table and joint capture
  always_ff @(posedge clk) begin
    if (in_acc && (in_op == dhfk_pkg::OP_LINK) && idx_ok) begin
      tbl[tbl_addr] <= '{kind:   in_joint_kind,
                         offset: in_word0,
                         length: in_word1,
                         tw_cos: in_word2,
                         tw_sin: in_word3,
                         an_cos: in_word4,
                         an_sin: in_word5};
    end
    if (joint_go) begin
      link_r  <= tbl[tbl_addr];
      w0_r    <= in_word0;
      idx_r   <= in_index;
      final_r <= in_final_joint;
    end
  end

  // angle terms, link products and accumulation
  always_ff @(posedge clk) begin
    if (state_r == ST_SEL) begin
      if (link_r.kind) begin
        ct_r <= link_r.an_cos;
        st_r <= link_r.an_sin;
        dd_r <= w0_r;
      end else begin
        dd_r <= link_r.offset;
      end
    end
    if ((state_r == ST_TRIG) && cor_done) begin
      ct_r <= cor_cos;
      st_r <= cor_sin;
    end
    if ((state_r == ST_LINK) && mul_fin) begin
      if ((lk_r == 3'd0) || (lk_r == 3'd4)) begin
        lmp_r[lk_r] <= dhfk_pkg::sat32(-mul_prod);
      end else begin
        lmp_r[lk_r] <= dhfk_pkg::sat32(mul_prod);
      end
    end
    if ((state_r == ST_MAT) && mul_fin) begin
      case (k_r)
        2'd0:    acc_r <= mul_prod + ((c_r == 2'd3) ? 64'(lhs) : 64'sd0);
        2'd1:    acc_r <= acc_r + mul_prod;
        default: res_r[r_r][c_r] <= dhfk_pkg::sat32(acc_r + mul_prod);
      endcase
    end
  end

  // frames, identity at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          base_r[i][j]  <= (i == j) ? ONE_Q : 32'sd0;
          tool_r[i][j]  <= (i == j) ? ONE_Q : 32'sd0;
          chain_r[i][j] <= (i == j) ? ONE_Q : 32'sd0;
        end
      end
    end else begin
      if (in_acc && (in_op == dhfk_pkg::OP_BASE) && row_ok) begin
        base_r[in_index[1:0]] <= '{in_word0, in_word1, in_word2, in_word3};
      end
      if (in_acc && (in_op == dhfk_pkg::OP_TOOL) && row_ok) begin
        tool_r[in_index[1:0]] <= '{in_word0, in_word1, in_word2, in_word3};
      end
      // joint zero restarts from the base frame
      if (joint_go && (in_index == 3'd0)) begin
        chain_r <= base_r;
      end else if ((state_r == ST_EMIT) && out_acc && last_row && !tool_pass_r) begin
        chain_r <= res_r;
      end
    end
  end

  // output word
  assign out_frame_index = idx_r;
  assign out_row         = er_r;
  assign out_elem0       = res_r[er_r][0];
  assign out_elem1       = res_r[er_r][1];
  assign out_elem2       = res_r[er_r][2];
  assign out_elem3       = res_r[er_r][3];
  assign out_is_tool     = tool_pass_r;
  assign out_end_of_run  = last_row && (tool_pass_r || !final_r);

endmodule
`default_nettype wire

### verif/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int SETTLE_CYCLES  = 60;
  localparam int Q_ONE          = 65536;

  typedef int frame_t [12];

  // one input word as queued for the driver
  typedef struct {
    dhfk_pkg::op_t   op;
    logic [2:0]      index;
    logic            kind;
    logic [31:0]     w [6];
    logic            fin;
  } dh_word_t;

  // one expected output row
  typedef struct {
    logic [2:0]  fidx;
    logic [1:0]  row;
    logic [31:0] e [4];
    logic        tool;
    logic        eor;
  } dh_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = '0;
  logic [2:0]  in_index = '0;
  logic        in_joint_kind = 1'b0;
  logic signed [31:0] in_word0 = '0, in_word1 = '0, in_word2 = '0;
  logic signed [31:0] in_word3 = '0, in_word4 = '0, in_word5 = '0;
  logic        in_final_joint = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_frame_index;
  logic [1:0]  out_row;
  logic signed [31:0] out_elem0, out_elem1, out_elem2, out_elem3;
  logic        out_is_tool;
  logic        out_end_of_run;

  dh_forward_kinematics_chain_top dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic        lk_kind [8];
  int          lk_off [8], lk_len [8], lk_tcos [8], lk_tsin [8], lk_acos [8], lk_asin [8];
  frame_t      base_m, tool_m, chain_m;
  bit          gen_written [8];

  dh_word_t pending_words [$];
  dh_row_t  expected_rows [$];
  dh_word_t cur_word;

  int  send_idle_pct = 0, recv_idle_pct = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  bit  word_taken = 0;
  int  mismatches = 0, rows_checked = 0, joints_seen = 0, loads_seen = 0, quiet_cycles = 0;

  function automatic int sat_q(longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return int'(v);
  endfunction

  // rounded Q16 product, unsaturated
  function automatic longint qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic frame_t identity_frame();
    frame_t m;
    foreach (m[i]) m[i] = 0;
    m[0] = Q_ONE; m[5] = Q_ONE; m[10] = Q_ONE;
    return m;
  endfunction

  function automatic frame_t frame_mul(frame_t l, frame_t r);
    frame_t t;
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int c = 0; c < 4; c++) begin
        acc = (c == 3) ? longint'(l[i*4+3]) : 64'sd0;
        for (int k = 0; k < 3; k++) acc += qmul(l[i*4+k], r[k*4+c]);
        t[i*4+c] = sat_q(acc);
      end
    return t;
  endfunction

  // rotation-mode CORDIC with quadrant fold, Q30 internally
  task automatic cordic_cs(input int ang, output int c, output int s);
    longint z, x, y, nx, xs, ys;
    bit flip;
    z = longint'(ang) * 64'sd16384;
    x = dhfk_pkg::GAIN_Q30; y = 0; flip = 0;
    z = z % dhfk_pkg::TWO_PI_Q30;
    if (z > dhfk_pkg::PI_Q30) z -= dhfk_pkg::TWO_PI_Q30;
    if (z < -dhfk_pkg::PI_Q30) z += dhfk_pkg::TWO_PI_Q30;
    if (z > dhfk_pkg::HALF_PI_Q30) begin z -= dhfk_pkg::PI_Q30; flip = 1; end
    else if (z < -dhfk_pkg::HALF_PI_Q30) begin z += dhfk_pkg::PI_Q30; flip = 1; end
    for (int i = 0; i < dhfk_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        nx = x - ys; y = y + xs; z -= longint'(dhfk_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + ys; y = y - xs; z += longint'(dhfk_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    if (flip) begin x = -x; y = -y; end
    c = sat_q((x + 64'sd8192) >>> 14);
    s = sat_q((y + 64'sd8192) >>> 14);
  endtask

  task automatic queue_rows(frame_t m, logic [2:0] fidx, bit tool, bit eor_last);
    dh_row_t r;
    for (int i = 0; i < 3; i++) begin
      r.fidx = fidx; r.row = i[1:0]; r.tool = tool;
      for (int c = 0; c < 4; c++) r.e[c] = m[i*4+c];
      r.eor = eor_last && (i == 2);
      expected_rows = {expected_rows, r};
    end
  endtask

  // update the link table / frames and queue the rows a word causes
  task automatic predict_word(dh_word_t w);
    frame_t lm;
    int ct, st, ca, sa, ln, dd, ix;
    ix = w.index;
    case (w.op) inside
      dhfk_pkg::OP_BASE, dhfk_pkg::OP_TOOL: begin
        loads_seen++;
        if (ix < 3)
          for (int c = 0; c < 4; c++)
            if (w.op == dhfk_pkg::OP_BASE) base_m[ix*4+c] = w.w[c];
            else tool_m[ix*4+c] = w.w[c];
      end
      dhfk_pkg::OP_LINK: begin
        loads_seen++;
        lk_kind[ix] = w.kind; lk_off[ix] = w.w[0]; lk_len[ix] = w.w[1];
        lk_tcos[ix] = w.w[2]; lk_tsin[ix] = w.w[3]; lk_acos[ix] = w.w[4]; lk_asin[ix] = w.w[5];
      end
      default: begin
        joints_seen++;
        ca = lk_tcos[ix]; sa = lk_tsin[ix]; ln = lk_len[ix];
        if (lk_kind[ix] == 1'b0) begin
          cordic_cs(w.w[0], ct, st);
          dd = lk_off[ix];
        end else begin
          ct = lk_acos[ix]; st = lk_asin[ix]; dd = w.w[0];
        end
        lm[0] = ct;  lm[1] = sat_q(-qmul(st, ca)); lm[2]  = sat_q(qmul(st, sa));
        lm[3] = sat_q(qmul(ln, ct));
        lm[4] = st;  lm[5] = sat_q(qmul(ct, ca));  lm[6]  = sat_q(-qmul(ct, sa));
        lm[7] = sat_q(qmul(ln, st));
        lm[8] = 0;   lm[9] = sa;                   lm[10] = ca; lm[11] = dd;
        if (ix == 0) chain_m = base_m;
        chain_m = frame_mul(chain_m, lm);
        queue_rows(chain_m, w.index, 1'b0, !w.fin);
        if (w.fin) queue_rows(frame_mul(chain_m, tool_m), w.index, 1'b1, 1'b1);
      end
    endcase
  endtask

  // stimulus helpers
  function automatic logic [31:0] rnd_word();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 2) return $urandom;
    if (sel == 2) return 32'h7FFFFFFF;
    if (sel == 3) return 32'h80000000;
    return $urandom_range(0, 524288) - 262144;
  endfunction

  task automatic add_link(int ix, bit kind, logic [31:0] d, logic [31:0] a, logic [31:0] tc,
                          logic [31:0] ts, logic [31:0] ac, logic [31:0] as_v);
    dh_word_t w;
    w.op = dhfk_pkg::OP_LINK; w.index = ix[2:0]; w.kind = kind; w.fin = $urandom_range(0, 1);
    w.w[0] = d; w.w[1] = a; w.w[2] = tc; w.w[3] = ts; w.w[4] = ac; w.w[5] = as_v;
    gen_written[ix] = 1;
    pending_words = {pending_words, w};
  endtask

  task automatic add_rand_link(int ix);
    add_link(ix, $urandom_range(0, 1), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
             rnd_word(), rnd_word());
  endtask

  task automatic add_row(dhfk_pkg::op_t op, int ix, logic [31:0] a, logic [31:0] b,
                         logic [31:0] c, logic [31:0] d);
    dh_word_t w;
    w.op = op; w.index = ix[2:0]; w.kind = $urandom_range(0, 1); w.fin = $urandom_range(0, 1);
    w.w[0] = a; w.w[1] = b; w.w[2] = c; w.w[3] = d; w.w[4] = $urandom; w.w[5] = $urandom;
    pending_words = {pending_words, w};
  endtask

  task automatic add_joint(int ix, logic [31:0] val, bit fin);
    dh_word_t w;
    w.op = dhfk_pkg::OP_JOINT; w.index = ix[2:0]; w.kind = $urandom_range(0, 1); w.fin = fin;
    w.w[0] = val;
    for (int i = 1; i < 6; i++) w.w[i] = $urandom;
    pending_words = {pending_words, w};
  endtask

  function automatic logic [31:0] rnd_joint();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 1647100) - 823550;
  endfunction

  // one well-formed chain, with occasional noise
  task automatic add_chain();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      if (!gen_written[i] || $urandom_range(0, 1)) add_rand_link(i);
    if ($urandom_range(0, 3) == 0)
      add_row($urandom_range(0, 1) ? dhfk_pkg::OP_BASE : dhfk_pkg::OP_TOOL,
              $urandom_range(0, 7), rnd_word(), rnd_word(), rnd_word(), rnd_word());
    for (int i = 0; i < n; i++) begin
      add_joint(i, rnd_joint(), (i == n - 1) ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 15) == 0));
      if ($urandom_range(0, 19) == 0) add_joint($urandom_range(0, n - 1), rnd_joint(), 0);
    end
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid && expected_rows.size() == 0);
    @(posedge clk);
  endtask

  task automatic run_random(int count);
    int target;
    target = pending_words.size() + count;
    while (pending_words.size() < target) add_chain();
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_taken)) begin
      word_taken = 0;
      if (pending_words.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        cur_word = pending_words.pop_front();
        in_op <= cur_word.op; in_index <= cur_word.index; in_joint_kind <= cur_word.kind;
        in_word0 <= cur_word.w[0]; in_word1 <= cur_word.w[1]; in_word2 <= cur_word.w[2];
        in_word3 <= cur_word.w[3]; in_word4 <= cur_word.w[4]; in_word5 <= cur_word.w[5];
        in_final_joint <= cur_word.fin;
        in_valid <= 1'b1;
      end
    end
  end

  // output stall driver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_cnt > 0) hold_cnt--;
    out_stall <= (hold_cnt > 0) || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    dh_row_t exp_r;
    logic [31:0] got [4];
    bit bad;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        predict_word(cur_word);
        word_taken = 1;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        got[0] = out_elem0; got[1] = out_elem1; got[2] = out_elem2; got[3] = out_elem3;
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected row frame %0d row %0d", out_frame_index, out_row);
        end else begin
          exp_r = expected_rows.pop_front();
          rows_checked++;
          bad = (out_frame_index !== exp_r.fidx) || (out_row !== exp_r.row) ||
                (out_is_tool !== exp_r.tool) || (out_end_of_run !== exp_r.eor);
          for (int c = 0; c < 4; c++) bad |= (got[c] !== exp_r.e[c]);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: row mismatch: exp idx %0d row %0d tool %0d eor %0d %h %h %h %h",
                       exp_r.fidx, exp_r.row, exp_r.tool, exp_r.eor, exp_r.e[0], exp_r.e[1],
                       exp_r.e[2], exp_r.e[3], "\n       got idx %0d row %0d tool %0d eor %0d",
                       out_frame_index, out_row, out_is_tool, out_end_of_run,
                       " %h %h %h %h", got[0], got[1], got[2], got[3]);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    base_m = identity_frame(); tool_m = identity_frame(); chain_m = identity_frame();
    foreach (gen_written[i]) gen_written[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both link kinds, frames, ignored rows, restart and reorder
    add_link(0, 0, 32'h00010000, 32'h00020000, 32'h00010000, 32'h0, 32'h0, 32'h0);
    add_link(1, 1, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h00010000, 32'h0000B505, 32'h0000B505);
    add_link(2, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
             32'hFFFFFFFF);
    add_link(7, 1, 32'hFFFFFFFF, 32'h0, 32'hFFFF0000, 32'h0, 32'h80000000, 32'h7FFFFFFF);
    add_joint(0, 32'h0, 0);
    add_joint(1, 32'h00030000, 0);
    add_joint(2, 32'h7FFFFFFF, 1);
    add_joint(0, 32'h80000000, 0);
    add_joint(0, 32'h0003243F, 0);
    add_joint(0, 32'hFFFCDBC1, 1);
    add_joint(0, 32'h0001921F, 0);
    add_row(dhfk_pkg::OP_BASE, 0, 32'h0, 32'hFFFF0000, 32'h0, 32'h00050000);
    add_row(dhfk_pkg::OP_BASE, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_row(dhfk_pkg::OP_TOOL, 2, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'h00001000);
    add_row(dhfk_pkg::OP_TOOL, 7, 32'h0, 32'h0, 32'h0, 32'h0);
    add_joint(0, 32'hFFFE6DE1, 0);
    add_joint(7, 32'h12345678, 0);
    add_joint(1, 32'h0, 1);
    add_joint(2, 32'h00010000, 0);
    add_row(dhfk_pkg::OP_BASE, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_joint(0, 32'h00008000, 1);
    drain();

    send_idle_pct = 16; recv_idle_pct = 74;
    run_random(100);
    drain();

    send_idle_pct = 74; recv_idle_pct = 16;
    hold_req = 1;
    run_random(100);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(90);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d joint words and %0d load words, %0d rows checked,",
             joints_seen, loads_seen, rows_checked);
    $display("under sender and receiver idling, a long output hold-off and a full drain.");
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d rows never seen", mismatches, expected_rows.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
hw/rtl/dhfk_pkg.sv
hw/rtl/dhfk_mul.sv
hw/rtl/dhfk_cordic.sv
hw/rtl/dh_forward_kinematics_chain_top.sv
verif/testbench.sv
